### hdl/uer_pkg.sv
// Package for the ultrasonic echo ranger: payload structs, phase codes,
// register indexes and fixed field widths. No dependencies.
`default_nettype none

package uer_pkg;

  localparam int ADC_W  = 10;
  localparam int TIME_W = 24;
  localparam int DIST_W = 22;
  localparam int PEAK_W = 10;
  localparam int MV_W   = 12;
  localparam int REG_W  = 32;

  // Distance is time * DIST_NUM / DIST_DEN, kept as a running quotient.
  localparam int DIST_NUM = 343;
  localparam int DIST_DEN = 2000;
  localparam int MV_SCALE = 3300;

  localparam logic [15:0] BURST_RST   = 16'd150;
  localparam logic [15:0] BLANK_RST   = 16'd2500;
  localparam logic [23:0] TIMEOUT_RST = 24'd30000;
  localparam logic [23:0] HOLDOFF_RST = 24'd100000;

  typedef enum logic [1:0] {
    REG_BURST   = 2'd0,
    REG_BLANK   = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_HOLDOFF = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BURST = 3'd1,
    PH_BLANK = 3'd2,
    PH_WAIT  = 3'd3,
    PH_PULSE = 3'd4,
    PH_HOLD  = 3'd5
  } phase_t;

  typedef struct packed {
    logic              start_request;
    logic              echo_level;
    logic              sample_valid;
    logic [ADC_W-1:0]  adc_sample;
  } in_item_t;

  typedef struct packed {
    logic              trigger_drive;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [TIME_W-1:0] echo_time_us;
    logic [DIST_W-1:0] distance_mm;
    logic [PEAK_W-1:0] peak_sample;
    logic [MV_W-1:0]   peak_millivolts;
    logic [TIME_W-1:0] pulse_length_us;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level: phase sequencer, counters, APB registers
// and a two-entry result buffer. Depends on uer_pkg.
//
//   channel   ports                                  direction
//   input     in_valid, in_stall, in_data            one microsecond tick in
//   result    out_valid, out_stall, out_data         one result per tick out
//   config    psel, penable, pwrite, paddr, pwdata,  APB register access
//             prdata, pready
//
// One tick is accepted every cycle while in_stall is low; its result is registered
// in the output or skid register. Distance is kept as a running quotient and remainder
// beside the flight counter, so no divider sits in the path.
// Reset is synchronous and active low; it restores the phase, counters and
// registers at once. A stalled result moves into a skid register, and in_stall
// rises only when both the output and skid registers are full.
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int COUNT_WIDTH  = 24,
  parameter int SAMPLE_WIDTH = 10
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  uer_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output uer_pkg::out_item_t  out_data,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [3:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import uer_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // Configuration registers
  logic [15:0] burst_r, blank_r;
  logic [23:0] timeout_r, holdoff_r;

  // Sequencer state
  phase_t                  phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]  phase_cnt_r, phase_cnt_nxt;
  logic [COUNT_WIDTH-1:0]  flight_cnt_r, flight_cnt_nxt;
  logic [COUNT_WIDTH-1:0]  pulse_cnt_r, pulse_cnt_nxt;
  logic [SAMPLE_WIDTH-1:0] peak_r, peak_nxt;
  logic [DIST_W-1:0]       dist_q_r, dist_q_nxt;
  logic [10:0]             dist_rem_r, dist_rem_nxt;

  // Result buffer
  logic      out_valid_r, skid_valid_r;
  out_item_t out_data_r, skid_data_r;
  out_item_t res;

  logic                    in_acc;
  logic                    cfg_wr;
  logic                    start_now;
  logic                    flight_step;
  logic                    phase_known;
  logic [COUNT_WIDTH-1:0]  pc_inc;
  logic [15:0]             sample_ext;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic [11:0]             rem_sum;
  logic [31:0]             fc_ext;
  logic [15:0]             peak_ext;
  logic [21:0]             mv_prod;

  function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
                                   input logic [31:0] lim);
    return (32'(c) >= lim) || (c == CNT_MAX);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  assign in_acc   = in_valid && !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- APB port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r   <= BURST_RST;
      blank_r   <= BLANK_RST;
      timeout_r <= TIMEOUT_RST;
      holdoff_r <= HOLDOFF_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BURST:   burst_r   <= pwdata[15:0];
        REG_BLANK:   blank_r   <= pwdata[15:0];
        REG_TIMEOUT: timeout_r <= pwdata[23:0];
        REG_HOLDOFF: holdoff_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BURST:   prdata = 32'(burst_r);
      REG_BLANK:   prdata = 32'(blank_r);
      REG_TIMEOUT: prdata = 32'(timeout_r);
      REG_HOLDOFF: prdata = 32'(holdoff_r);
      default:     prdata = '0;
    endcase
  end

  // ----------------------------------------------------------- state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      phase_cnt_r  <= '0;
      flight_cnt_r <= '0;
      pulse_cnt_r  <= '0;
      peak_r       <= '0;
      dist_q_r     <= '0;
      dist_rem_r   <= '0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      phase_cnt_r  <= phase_cnt_nxt;
      flight_cnt_r <= flight_cnt_nxt;
      pulse_cnt_r  <= pulse_cnt_nxt;
      peak_r       <= peak_nxt;
      dist_q_r     <= dist_q_nxt;
      dist_rem_r   <= dist_rem_nxt;
    end
  end

  // ------------------------------------------------- next state and result
  always_comb begin
    sample_ext = 16'(in_data.adc_sample);
    sample     = sample_ext[SAMPLE_WIDTH-1:0];

    phase_known = (phase_r == PH_BURST) || (phase_r == PH_BLANK) ||
                  (phase_r == PH_WAIT)  || (phase_r == PH_PULSE) ||
                  (phase_r == PH_HOLD);
    start_now   = in_data.start_request && !phase_known;

    phase_nxt      = phase_r;
    phase_cnt_nxt  = phase_cnt_r;
    flight_cnt_nxt = flight_cnt_r;
    pulse_cnt_nxt  = pulse_cnt_r;
    peak_nxt       = peak_r;
    dist_q_nxt     = dist_q_r;
    dist_rem_nxt   = dist_rem_r;
    flight_step    = 1'b0;
    res            = '0;

    if (start_now) begin
      phase_nxt      = PH_BURST;
      phase_cnt_nxt  = '0;
      flight_cnt_nxt = '0;
      pulse_cnt_nxt  = '0;
      peak_nxt       = '0;
      dist_q_nxt     = '0;
      dist_rem_nxt   = '0;
    end

    pc_inc = sat_inc(phase_cnt_nxt);

    unique case (phase_nxt)
      PH_BURST: begin
        res.trigger_drive = 1'b1;
        res.busy_res      = 1'b1;
        flight_step       = 1'b1;
        phase_cnt_nxt     = pc_inc;
        if (reached(pc_inc, 32'(burst_r))) begin
          phase_cnt_nxt = '0;
          phase_nxt     = (blank_r == '0) ? PH_WAIT : PH_BLANK;
        end
      end
      PH_BLANK: begin
        res.busy_res  = 1'b1;
        flight_step   = 1'b1;
        phase_cnt_nxt = pc_inc;
        if (reached(pc_inc, 32'(blank_r))) begin
          phase_cnt_nxt = '0;
          phase_nxt     = PH_WAIT;
        end
      end
      PH_WAIT: begin
        res.busy_res  = 1'b1;
        flight_step   = 1'b1;
        phase_cnt_nxt = pc_inc;
        if (in_data.echo_level) begin
          phase_nxt     = PH_PULSE;
          pulse_cnt_nxt = '0;
          peak_nxt      = '0;
        end else if (reached(pc_inc, 32'(timeout_r))) begin
          res.done_res  = 1'b1;
          res.timed_out = 1'b1;
          phase_cnt_nxt = '0;
          phase_nxt     = (holdoff_r == '0) ? PH_IDLE : PH_HOLD;
        end
      end
      PH_PULSE: begin
        res.busy_res  = 1'b1;
        pulse_cnt_nxt = sat_inc(pulse_cnt_r);
        if (in_data.sample_valid) begin
          // The pulse ends on a valid sample below half the running peak.
          if ({sample, 1'b0} < {1'b0, peak_r}) begin
            res.done_res = 1'b1;
            phase_cnt_nxt = '0;
            phase_nxt     = (holdoff_r == '0) ? PH_IDLE : PH_HOLD;
          end else if (sample > peak_r) begin
            peak_nxt = sample;
          end
        end
      end
      PH_HOLD: begin
        res.busy_res  = 1'b1;
        phase_cnt_nxt = pc_inc;
        if (reached(pc_inc, 32'(holdoff_r))) begin
          phase_cnt_nxt = '0;
          phase_nxt     = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // The distance quotient advances with the flight counter and stops with it.
    rem_sum = {1'b0, dist_rem_nxt} + 12'(DIST_NUM);
    if (flight_step && (flight_cnt_nxt != CNT_MAX)) begin
      flight_cnt_nxt = flight_cnt_nxt + 1'b1;
      if (rem_sum >= 12'(DIST_DEN)) begin
        dist_rem_nxt = 11'(rem_sum - 12'(DIST_DEN));
        dist_q_nxt   = dist_q_nxt + 1'b1;
      end else begin
        dist_rem_nxt = rem_sum[10:0];
      end
    end

    fc_ext   = 32'(flight_cnt_r);
    peak_ext = 16'(peak_r);
    mv_prod  = 22'(peak_ext[PEAK_W-1:0]) * 22'(MV_SCALE);
    if (res.done_res && !res.timed_out) begin
      res.echo_time_us    = fc_ext[TIME_W-1:0];
      res.distance_mm     = dist_q_r;
      res.peak_sample     = peak_ext[PEAK_W-1:0];
      res.peak_millivolts = mv_prod[21:10];
      res.pulse_length_us = 24'(32'(pulse_cnt_nxt));
    end
  end

  // ------------------------------------------------------------ result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_acc) begin
        out_data_r <= res;
      end
    end else if (in_acc) begin
      skid_data_r <= res;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a transaction while the output is empty");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.done_res) |-> (out_data.busy_res && !out_data.trigger_drive))
    else $error("result transaction marked done outside a measurement");

  a_timeout_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.timed_out) |->
      (out_data.done_res && (out_data.echo_time_us == '0) && (out_data.peak_sample == '0)))
    else $error("timeout transaction carries measurement data");

  a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && in_valid && !in_stall) |=> skid_valid_r)
    else $error("transaction accepted under stall did not reach the skid register");
`endif

endmodule

`default_nettype wire
